[rtl/core/assert_macros.svh]
// assertion helpers for the page table manager
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[rtl/core/tlpt_pkg.sv]
// ----------------------------------------------------------------------------
// tlpt_pkg
// shared types and constants of the two-level page table manager
// ----------------------------------------------------------------------------
package tlpt_pkg;
  localparam int unsigned DirCount   = 1024;
  localparam int unsigned TabEntries = 1024;
  localparam int unsigned EntryW     = 23;

  typedef enum logic [1:0] {
    OP_MAP       = 2'd0,
    OP_UNMAP     = 2'd1,
    OP_TRANSLATE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD        = 3'd1,
    ST_NO_TABLE   = 3'd2,
    ST_ALREADY    = 3'd3,
    ST_NOT_MAPPED = 3'd4
  } status_e;

  localparam logic CfgStart = 1'b0;
  localparam logic CfgEnd   = 1'b1;

  // entry layout: bit 0 present, bit 1 writable, bit 2 user, 22:3 frame
  localparam int unsigned EntPresent  = 0;
  localparam int unsigned EntWritable = 1;
  localparam int unsigned EntUser     = 2;
endpackage

[rtl/core/tlpt_if.sv]
// ----------------------------------------------------------------------------
// tlpt interfaces
// request, result and configuration channels
// ----------------------------------------------------------------------------
interface tlpt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] vaddr;
  logic [31:0] paddr;
  logic        writable;
  logic        user;
  logic        illegal_flags;
  modport source (output valid, operation, vaddr, paddr,
                  writable, user, illegal_flags, input ready);
  modport sink   (input valid, operation, vaddr, paddr,
                  writable, user, illegal_flags, output ready);
endinterface

interface tlpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] result_address;
  modport source (output valid, status, result_address, input ready);
  modport sink   (input valid, status, result_address, output ready);
endinterface

interface tlpt_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [20:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/tlpt_ram.sv]
// ----------------------------------------------------------------------------
// tlpt_ram
// generic synchronous ram with one write port and one registered read port
// ----------------------------------------------------------------------------
module tlpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/core/two_level_page_table_manager.sv]
// request path: idle, read, decide, entry when the entry ram is visited, resp
// allocating a table first clears its 1024 entries in the wipe state
// one request in flight, the next taken in the same cycle a result is raised
// a result held by the receiver stalls the next request at the result register
// reset: directory is swept clear, all 1024 entries, while no request is accepted
// ----------------------------------------------------------------------------
// two_level_page_table_manager
// sequencer over a directory ram and an entry ram with per-slot live counts
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_level_page_table_manager
  import tlpt_pkg::*;
#(
  parameter int unsigned DYNAMIC_SLOTS   = 32,
  parameter int unsigned IDENTITY_TABLES = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  tlpt_req_if.sink   req_i,
  tlpt_rsp_if.source rsp_o,
  tlpt_cfg_if.sink   cfg_i
);
  localparam int unsigned SlotW = (DYNAMIC_SLOTS > 1) ? $clog2(DYNAMIC_SLOTS) : 1;
  localparam int unsigned DirW  = SlotW + 2;           // valid, user, slot
  localparam int unsigned EntAw = SlotW + 10;
  localparam int unsigned CntW  = 11;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_DECIDE, S_WIPE, S_ENTRY, S_RESP
  } state_e;

  state_e state_q;
  logic [9:0]  sweep_q;
  logic [1:0]  op_q;
  logic [31:0] va_q, pa_q;
  logic        wr_q, us_q, badf_q;
  logic [19:0] start_q;
  logic [20:0] end_q;
  logic [SlotW-1:0] slot_q;
  logic        dir_user_q;
  logic        rsp_valid_q;
  logic [2:0]  rsp_status_q;
  logic [31:0] rsp_addr_q;
  logic [2:0]  status_q;
  logic [31:0] addr_q;
  logic [DYNAMIC_SLOTS-1:0] busy_q;
  logic [CntW-1:0] cnt_q [DYNAMIC_SLOTS];

  // directory ram
  logic            dir_we;
  logic [9:0]      dir_waddr, dir_raddr;
  logic [DirW-1:0] dir_wdata, dir_rdata;
  // entry ram
  logic              ent_we;
  logic [EntAw-1:0]  ent_waddr, ent_raddr;
  logic [EntryW-1:0] ent_wdata, ent_rdata;

  tlpt_ram #(.Width(DirW), .Depth(DirCount)) u_dir (
    .clk_i, .we_i(dir_we), .waddr_i(dir_waddr), .wdata_i(dir_wdata),
    .raddr_i(dir_raddr), .rdata_o(dir_rdata));
  tlpt_ram #(.Width(EntryW), .Depth((32'd1 << SlotW) * TabEntries)) u_ent (
    .clk_i, .we_i(ent_we), .waddr_i(ent_waddr), .wdata_i(ent_wdata),
    .raddr_i(ent_raddr), .rdata_o(ent_rdata));

  logic [9:0] dir_idx, ent_idx;
  assign dir_idx = va_q[31:22];
  assign ent_idx = va_q[21:12];

  // request checks
  logic win_ok, map_ok, is_ident;
  assign is_ident = {22'd0, dir_idx} < IDENTITY_TABLES;
  assign win_ok = ({1'b0, va_q[31:12]} >= {1'b0, start_q}) &&
                  ({1'b0, va_q[31:12]} < end_q) &&
                  (va_q[11:0] == 12'd0) && !is_ident;
  assign map_ok = win_ok && (pa_q[11:0] == 12'd0) && !badf_q;

  // lowest free slot
  logic             free_found;
  logic [SlotW-1:0] free_slot;
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = DYNAMIC_SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_slot  = SlotW'(i);
      end
    end
  end

  logic dir_valid;
  assign dir_valid = dir_rdata[DirW-1];

  // directory decision
  logic        dec_alloc;
  logic        dec_entry;
  status_e     dec_status;
  logic [31:0] dec_addr;
  assign dec_alloc = (op_q == OP_MAP) && map_ok && !dir_valid && free_found;
  always_comb begin
    dec_status = ST_BAD;
    dec_addr   = '0;
    dec_entry  = 1'b0;
    case (op_q)
      OP_MAP: begin
        if (map_ok) begin
          if (dir_valid) dec_entry = 1'b1;
          else dec_status = ST_NO_TABLE;
        end
      end
      OP_UNMAP: begin
        if (win_ok) begin
          dec_status = ST_NOT_MAPPED;
          dec_entry  = dir_valid;
        end
      end
      OP_TRANSLATE: begin
        dec_status = ST_NOT_MAPPED;
        if (is_ident) begin
          if (va_q[31:12] != 20'd0) begin
            dec_status = ST_OK;
            dec_addr   = va_q;
          end
        end else begin
          dec_entry = dir_valid;
        end
      end
      default: ;
    endcase
  end

  // result register loads when empty or being drained
  logic rsp_load;
  assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp_o.ready);

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.status = rsp_status_q;
  assign rsp_o.result_address = rsp_addr_q;

  // ram port steering
  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = dir_idx;
    dir_wdata = '0;
    dir_raddr = dir_idx;
    ent_we    = 1'b0;
    ent_waddr = {slot_q, ent_idx};
    ent_wdata = '0;
    ent_raddr = {slot_q, ent_idx};
    case (state_q)
      S_CLEAR: begin
        dir_we    = 1'b1;
        dir_waddr = sweep_q;
      end
      S_DECIDE: begin
        ent_raddr = {dir_rdata[SlotW-1:0], ent_idx};
        if (dec_alloc) begin
          dir_we    = 1'b1;
          dir_wdata = {1'b1, 1'b0, free_slot};
        end
      end
      S_WIPE: begin
        ent_we    = 1'b1;
        ent_waddr = {slot_q, sweep_q};
      end
      S_ENTRY: begin
        if (op_q == OP_MAP && !ent_rdata[EntPresent]) begin
          ent_we    = 1'b1;
          ent_wdata = {pa_q[31:12], us_q, wr_q, 1'b1};
          dir_we    = 1'b1;
          dir_wdata = {1'b1, dir_user_q | us_q, slot_q};
        end else if (op_q == OP_UNMAP && ent_rdata[EntPresent]) begin
          ent_we = 1'b1;
          if (cnt_q[slot_q] <= CntW'(1)) begin
            dir_we = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      sweep_q      <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= ST_OK;
      rsp_addr_q   <= '0;
      status_q     <= ST_OK;
      addr_q       <= '0;
      op_q         <= OP_MAP;
      va_q         <= '0;
      pa_q         <= '0;
      wr_q         <= 1'b0;
      us_q         <= 1'b0;
      badf_q       <= 1'b0;
      slot_q       <= '0;
      dir_user_q   <= 1'b0;
      start_q      <= 20'd32768;
      end_q        <= 21'd262144;
      busy_q       <= '0;
      for (int i = 0; i < DYNAMIC_SLOTS; i++) cnt_q[i] <= '0;
    end else begin
      // configuration
      if (cfg_i.valid) begin
        if (cfg_i.index == CfgStart) start_q <= cfg_i.data[19:0];
        else end_q <= cfg_i.data;
      end
      // result register
      if (rsp_load) begin
        rsp_valid_q  <= 1'b1;
        rsp_status_q <= status_q;
        rsp_addr_q   <= addr_q;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          sweep_q <= sweep_q + 10'd1;
          if (sweep_q == 10'd1023) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req_i.valid && req_i.ready) begin
            op_q   <= req_i.operation;
            va_q   <= req_i.vaddr;
            pa_q   <= req_i.paddr;
            wr_q   <= req_i.writable;
            us_q   <= req_i.user;
            badf_q <= req_i.illegal_flags;
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_DECIDE;
        S_DECIDE: begin
          if (dec_alloc) begin
            slot_q     <= free_slot;
            dir_user_q <= 1'b0;
            busy_q[free_slot] <= 1'b1;
            cnt_q[free_slot]  <= '0;
            sweep_q <= '0;
            state_q <= S_WIPE;
          end else begin
            slot_q     <= dir_rdata[SlotW-1:0];
            dir_user_q <= dir_rdata[SlotW];
            status_q   <= dec_status;
            addr_q     <= dec_addr;
            state_q    <= dec_entry ? S_ENTRY : S_RESP;
          end
        end
        S_WIPE: begin
          sweep_q <= sweep_q + 10'd1;
          if (sweep_q == 10'd1023) state_q <= S_READ;
        end
        S_ENTRY: begin
          state_q <= S_RESP;
          case (op_q)
            OP_MAP: begin
              if (ent_rdata[EntPresent]) begin
                status_q <= ST_ALREADY;
              end else begin
                status_q <= ST_OK;
                cnt_q[slot_q] <= cnt_q[slot_q] + CntW'(1);
              end
            end
            OP_UNMAP: begin
              if (ent_rdata[EntPresent]) begin
                status_q <= ST_OK;
                addr_q   <= {ent_rdata[22:3], 12'd0};
                if (cnt_q[slot_q] <= CntW'(1)) begin
                  cnt_q[slot_q]  <= '0;
                  busy_q[slot_q] <= 1'b0;
                end else begin
                  cnt_q[slot_q] <= cnt_q[slot_q] - CntW'(1);
                end
              end
            end
            default: begin
              if (ent_rdata[EntPresent]) begin
                status_q <= ST_OK;
                addr_q   <= {ent_rdata[22:3], va_q[11:0]};
              end
            end
          endcase
        end
        S_RESP: begin
          if (rsp_load) state_q <= S_IDLE;
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  // requests are only taken by the idle sequencer
  `ASSERT_IMPL(a_req_idle, clk_i, rst_ni, req_i.ready, state_q == S_IDLE)
  // a held result stays valid with a stable status
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_o.valid && !rsp_o.ready,
               rsp_o.valid && $stable(rsp_o.status))
  // status is always a defined code
  `ASSERT_IMPL(a_status_range, clk_i, rst_ni, rsp_o.valid,
               rsp_o.status <= ST_NOT_MAPPED)
endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-level page table manager. A table of
// directed requests covers extremes and error codes, then random map, unmap
// and translate traffic runs over several window settings. Each result is
// compared with the bench's behavioural page table or its row's values.
// ----------------------------------------------------------------------------
module testbench;
  import tlpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumSlots   = 32;
  localparam int unsigned IdentDirs  = 32;
  localparam int unsigned CycleLimit = 4000000;
  localparam logic [1:0]  OpUnknown  = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] va;
    logic [31:0] pa;
    logic        wr;
    logic        us;
    logic        ill;
    logic        typed;
    logic [2:0]  st;
    logic [31:0] ad;
  } stim_row_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [31:0] ad;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tlpt_req_if req_if ();
  tlpt_rsp_if rsp_if ();
  tlpt_cfg_if cfg_if ();

  two_level_page_table_manager dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // page table mirror
  logic [19:0] win_start;
  logic [20:0] win_end;
  int unsigned dir_table [DirCount];
  logic        dir_user  [DirCount];
  logic        table_busy[NumSlots];
  int unsigned live_pages[NumSlots];
  logic [22:0] pte_mem   [NumSlots*TabEntries];

  outcome_t pending[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  function automatic bit in_window(logic [31:0] va);
    return va[31:12] >= win_start && {1'b0, va[31:12]} < win_end &&
           va[11:0] == 12'h000 && va[31:22] >= IdentDirs;
  endfunction

  // behavioural page table: returns status and address, updates the mirror
  function automatic outcome_t page_walk(logic [1:0] op, logic [31:0] va,
                                         logic [31:0] pa, logic wr, logic us,
                                         logic ill);
    outcome_t    r;
    int unsigned d;
    int unsigned slot;
    int unsigned pos;
    bit          have;
    d = 32'(va[31:22]);
    r.st = ST_BAD;
    r.ad = '0;
    if (op == OP_MAP) begin
      if (in_window(va) && pa[11:0] == 12'h000 && !ill) begin
        have = 1'b1;
        // allocate the lowest free table and clear it
        if (dir_table[d] == 0) begin
          have = 1'b0;
          for (int s = 0; s < NumSlots; s++) begin
            if (!have && !table_busy[s]) begin
              table_busy[s] = 1'b1;
              live_pages[s] = 0;
              for (int e = 0; e < TabEntries; e++) pte_mem[s*TabEntries+e] = '0;
              dir_table[d] = s + 1;
              dir_user[d] = 1'b0;
              have = 1'b1;
            end
          end
        end
        if (!have) begin
          r.st = ST_NO_TABLE;
        end else begin
          slot = dir_table[d] - 1;
          pos = slot*TabEntries + 32'(va[21:12]);
          if (pte_mem[pos][EntPresent]) begin
            r.st = ST_ALREADY;
          end else begin
            pte_mem[pos] = {pa[31:12], us, wr, 1'b1};
            if (us) dir_user[d] = 1'b1;
            live_pages[slot]++;
            r.st = ST_OK;
          end
        end
      end
    end else if (op == OP_UNMAP) begin
      if (in_window(va)) begin
        r.st = ST_NOT_MAPPED;
        if (dir_table[d] != 0) begin
          slot = dir_table[d] - 1;
          pos = slot*TabEntries + 32'(va[21:12]);
          if (pte_mem[pos][EntPresent]) begin
            r.ad = {pte_mem[pos][22:3], 12'h000};
            pte_mem[pos] = '0;
            if (live_pages[slot] != 0) live_pages[slot]--;
            // last page gone, give the table back
            if (live_pages[slot] == 0) begin
              table_busy[slot] = 1'b0;
              dir_table[d] = 0;
              dir_user[d] = 1'b0;
            end
            r.st = ST_OK;
          end
        end
      end
    end else if (op == OP_TRANSLATE) begin
      r.st = ST_NOT_MAPPED;
      if (d < IdentDirs) begin
        if (va[31:12] != 0) begin
          r.ad = va;
          r.st = ST_OK;
        end
      end else if (dir_table[d] != 0) begin
        pos = (dir_table[d] - 1)*TabEntries + 32'(va[21:12]);
        if (pte_mem[pos][EntPresent]) begin
          r.ad = {pte_mem[pos][22:3], va[11:0]};
          r.st = ST_OK;
        end
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
  endtask

  // idle burst on the request side
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // offer one request and wait for acceptance
  task automatic send_request(logic [1:0] op, logic [31:0] va, logic [31:0] pa,
                              logic wr, logic us, logic ill, logic typed,
                              logic [2:0] st, logic [31:0] ad);
    outcome_t o;
    maybe_gap();
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.vaddr <= va;
    req_if.paddr <= pa;
    req_if.writable <= wr;
    req_if.user <= us;
    req_if.illegal_flags <= ill;
    do @(posedge clk_i); while (!req_if.ready);
    o = page_walk(op, va, pa, wr, us, ill);
    if (typed) begin
      o.st = st;
      o.ad = ad;
    end
    pending.push_back(o);
  endtask

  // write a window register once the block is idle
  task automatic write_window(logic idx, logic [20:0] val);
    req_if.valid <= 1'b0;
    wait (pending.size() == 0);
    repeat (8) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CfgStart) win_start = val[19:0];
    else win_end = val;
  endtask

  function automatic logic [31:0] pick_page();
    int unsigned span;
    int unsigned off;
    span = (win_end > win_start) ? win_end - win_start : 0;
    if (span == 0 || $urandom_range(0, 9) == 0) return {$urandom()} & 32'hFFFF_F000;
    off = ($urandom_range(0, 5)*TabEntries + $urandom_range(0, 15)) % span;
    return (win_start + off) << 12;
  endfunction

  task automatic random_requests(int unsigned n);
    logic [31:0] va;
    logic [31:0] pa;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      va = pick_page();
      pa = {$urandom()} & 32'hFFFF_F000;
      if ($urandom_range(0, 19) == 0) pa = $urandom();
      if (pick < 45) begin
        send_request(OP_MAP, va, pa, 1'($urandom()), 1'($urandom()),
                     $urandom_range(0, 19) == 0, 1'b0, '0, '0);
      end else if (pick < 75) begin
        send_request(OP_UNMAP, va, $urandom(), 1'($urandom()), 1'($urandom()),
                     1'($urandom()), 1'b0, '0, '0);
      end else if (pick < 95) begin
        if (pick < 85) va = va | $urandom_range(0, 4095);
        else va = $urandom();
        send_request(OP_TRANSLATE, va, $urandom(), 1'($urandom()), 1'($urandom()),
                     1'($urandom()), 1'b0, '0, '0);
      end else begin
        // noise: unknown operation or unaligned address
        send_request(pick < 97 ? OpUnknown : OP_MAP, va | $urandom_range(1, 4095),
                     $urandom(), 1'($urandom()), 1'($urandom()), 1'($urandom()),
                     1'b0, '0, '0);
      end
    end
  endtask

  // directed table
  stim_row_t rows[] = '{
    '{OP_TRANSLATE, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1, ST_NOT_MAPPED, 32'h0},
    '{OP_TRANSLATE, 32'h0000_1234, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1, ST_OK, 32'h0000_1234},
    '{OP_TRANSLATE, 32'h07FF_FFFF, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1, ST_OK, 32'h07FF_FFFF},
    '{OP_TRANSLATE, 32'h0800_0000, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1, ST_NOT_MAPPED, 32'h0},
    '{OpUnknown, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, ST_BAD, 32'h0},
    '{OP_MAP, 32'h0800_0001, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1, ST_BAD, 32'h0},
    '{OP_MAP, 32'h0400_0000, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1, ST_BAD, 32'h0},
    '{OP_MAP, 32'h0800_0000, 32'h0000_0FFF, 1'b0, 1'b0, 1'b0, 1'b1, ST_BAD, 32'h0},
    '{OP_MAP, 32'h0800_0000, 32'h0, 1'b0, 1'b0, 1'b1, 1'b1, ST_BAD, 32'h0},
    '{OP_UNMAP, 32'h0400_0000, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1, ST_BAD, 32'h0},
    '{OP_MAP, 32'h0800_0000, 32'hFFFF_F000, 1'b1, 1'b1, 1'b0, 1'b1, ST_OK, 32'h0},
    '{OP_MAP, 32'h0800_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1, ST_ALREADY, 32'h0},
    '{OP_TRANSLATE, 32'h0800_0FFF, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1, ST_OK, 32'hFFFF_FFFF},
    '{OP_MAP, 32'h0800_1000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK, 32'h0},
    '{OP_UNMAP, 32'h0800_0000, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1, ST_OK, 32'hFFFF_F000},
    '{OP_UNMAP, 32'h0800_0000, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1, ST_NOT_MAPPED, 32'h0},
    '{OP_TRANSLATE, 32'h0800_1ABC, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK, 32'h0},
    '{OP_UNMAP, 32'h0800_1000, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK, 32'h0},
    '{OP_MAP, 32'h3FFF_F000, 32'h1234_5000, 1'b0, 1'b1, 1'b0, 1'b1, ST_OK, 32'h0},
    '{OP_MAP, 32'h4000_0000, 32'h1234_5000, 1'b0, 1'b0, 1'b0, 1'b1, ST_BAD, 32'h0},
    '{OP_UNMAP, 32'h3FFF_F000, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1, ST_OK, 32'h1234_5000}
  };

  // main sequence
  initial begin
    req_if.valid = 1'b0;
    req_if.operation = OP_TRANSLATE;
    req_if.vaddr = '0;
    req_if.paddr = '0;
    req_if.writable = 1'b0;
    req_if.user = 1'b0;
    req_if.illegal_flags = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CfgStart;
    cfg_if.data = '0;
    win_start = 20'd32768;
    win_end = 21'd262144;
    for (int d = 0; d < DirCount; d++) begin
      dir_table[d] = 0;
      dir_user[d] = 1'b0;
    end
    for (int s = 0; s < NumSlots; s++) begin
      table_busy[s] = 1'b0;
      live_pages[s] = 0;
    end
    for (int p = 0; p < NumSlots*TabEntries; p++) pte_mem[p] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i])
      send_request(rows[i].op, rows[i].va, rows[i].pa, rows[i].wr, rows[i].us,
                   rows[i].ill, rows[i].typed, rows[i].st, rows[i].ad);

    // widest window
    write_window(CfgEnd, 21'd1048576);
    random_requests(250);

    // empty window, both extremes
    write_window(CfgStart, 21'd1048575);
    write_window(CfgEnd, 21'd32768);
    random_requests(40);

    // narrow window
    write_window(CfgStart, 21'd40000);
    write_window(CfgEnd, 21'd41500);
    random_requests(200);

    // exhaust the table pool, then release it
    write_window(CfgStart, 21'd32768);
    write_window(CfgEnd, 21'd1048576);
    for (int d = 40; d < 76; d++)
      send_request(OP_MAP, d << 22, d << 12, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0);
    for (int d = 40; d < 76; d++)
      send_request(OP_UNMAP, d << 22, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0);

    // long receiver hold-off while requests keep coming
    hold_req = 1'b1;
    random_requests(250);
    calm = 1'b1;
    random_requests(120);
    req_if.valid <= 1'b0;

    wait (pending.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  // result side readiness
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // result check
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending.size() == 0) begin
        report("unexpected result", rsp_if.result_address, '0);
      end else begin
        want = pending.pop_front();
        if (rsp_if.status !== want.st)
          report("status", {29'd0, rsp_if.status}, {29'd0, want.st});
        if (rsp_if.result_address !== want.ad)
          report("result_address", rsp_if.result_address, want.ad);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end
endmodule
